FILE: sv/bgh_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the binned grey histogram unit.
// No dependencies; imported by every module of the block.
package bgh_pkg;

	localparam int GREY_LEVELS     = 256;
	localparam int COUNT_BITS      = 32;
	localparam int STORE_DEPTH     = 256;
	localparam int IDX_BITS        = $clog2(STORE_DEPTH);
	localparam int PIXEL_BITS      = 8;
	localparam int BC_BITS         = 9;
	localparam int STARS_BITS      = 16;
	localparam int CFG_DATA_BITS   = 16;
	localparam int CFG_INDEX_BITS  = 1;
	localparam int STEP_BITS       = $clog2(STARS_BITS);
	localparam int RECIP_SHIFT     = 16;
	localparam int RECIP_BITS      = RECIP_SHIFT + 1;
	localparam int STAR_SCALE_RESET = 1;
	localparam int BIN_COUNT_RESET  = 256;

	// Opcodes carried in s_tuser
	typedef enum logic [1:0] {
		OP_ADD   = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NOP   = 2'd3
	} opcode_t;

	// Configuration register indexes
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_STAR_SCALE = 1'b0,
		CFG_BIN_COUNT  = 1'b1
	} cfg_index_t;

	// Controller to datapath
	typedef struct packed {
		logic take;      // capture the input transaction
		logic clear;     // empty the store
		logic mem_rd;    // read the addressed bin
		logic mem_wr;    // write back the incremented bin
		logic mul_load;  // form count * scale and seed the divider
		logic div_step;  // one restoring division step
		logic load_out;  // load the output register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic in_range;  // captured bin lies below bin_count
		logic max_zero;  // histogram empty
		logic div_last;  // final division step in progress
		logic out_busy;  // output register holds an untaken result
	} sts_t;

endpackage

FILE: sv/binned_grey_histogram_unit.sv
`timescale 1ns / 1ps
// Binned grey-level histogram: top level joining bgh_ctrl and bgh_dp.
// Depends on bgh_pkg, bgh_ctrl and bgh_dp.
//
// Each transaction on the slave side carries an opcode in s_tuser: add a
// pixel, read a bin, clear the histogram, or do nothing. A pixel is counted
// into bin pixel / (256 / bin_count); pixels beyond the last bin are dropped
// and counts saturate at 32 bits. A read returns count * star_scale / max on
// m_tdata, rounded down, with no_data in m_tuser set (and 0 stars) while the
// histogram is empty; a bin at or above bin_count reads as 0 stars. Only
// reads produce a master-side transaction. The store is empty after reset and
// after a clear; a change of bin_count keeps the counts. One item is in work
// at a time: a clear or a no-op is done at once when taken; a pixel is a
// read then a write of the single-port bin store, and a dropped pixel skips
// both. A read goes through the store read, the scaling multiply and the
// 16-step serial divider before the output state, and skips straight to the
// output state when the answer is trivially zero. A finished read waits in the
// output register, and the next transaction is taken meanwhile. Configuration
// writes are taken at once (cfg_ready is always high) and must arrive while
// the block is idle; odd, zero or too-large bin_count writes are ignored.
module binned_grey_histogram_unit import bgh_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [15:0]               s_tdata,  // [7:0] pixel, [15:8] bin_index
	input  logic [1:0]                s_tuser,  // [1:0] opcode
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [15:0]               m_tdata,  // [15:0] stars
	output logic                      m_tuser,  // [0] no_data
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	cmd_t    cmd;
	sts_t    sts;
	opcode_t opcode;

	assign opcode    = opcode_t'(s_tuser);
	// registers are written in the same cycle; no back-pressure needed
	assign cfg_ready = 1'b1;

	bgh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.opcode   (opcode),
		.sts      (sts),
		.in_ready (s_tready),
		.cmd      (cmd)
	);

	bgh_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.opcode    (opcode),
		.pixel     (s_tdata[7:0]),
		.bin_index (s_tdata[15:8]),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.stars     (m_tdata),
		.no_data   (m_tuser)
	);

endmodule

FILE: sv/bgh_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine of the binned grey histogram unit.
// Depends on bgh_pkg for the command and status structs and opcodes.
module bgh_ctrl import bgh_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  opcode_t opcode,
	input  sts_t    sts,
	output logic    in_ready,
	output cmd_t    cmd
);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_ADD_RD = 7'b0000010,
		ST_ADD_WR = 7'b0000100,
		ST_RD_RD  = 7'b0001000,
		ST_RD_MUL = 7'b0010000,
		ST_RD_DIV = 7'b0100000,
		ST_RD_OUT = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_ready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					case (opcode)
						OP_ADD:   state_d = ST_ADD_RD;
						OP_READ:  state_d = ST_RD_RD;
						OP_CLEAR: cmd.clear = 1'b1;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_ADD_RD: begin
				// drop pixels beyond the last bin
				if (sts.in_range) begin
					cmd.mem_rd = 1'b1;
					state_d    = ST_ADD_WR;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_ADD_WR: begin
				cmd.mem_wr = 1'b1;
				state_d    = ST_IDLE;
			end
			ST_RD_RD: begin
				if (sts.in_range && !sts.max_zero) begin
					cmd.mem_rd = 1'b1;
					state_d    = ST_RD_MUL;
				end else begin
					state_d = ST_RD_OUT;
				end
			end
			ST_RD_MUL: begin
				cmd.mul_load = 1'b1;
				state_d      = ST_RD_DIV;
			end
			ST_RD_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_RD_OUT;
				end
			end
			ST_RD_OUT: begin
				if (!sts.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: sv/bgh_dp.sv
`timescale 1ns / 1ps
// Datapath of the binned grey histogram unit: configuration, bin store,
// binning multiplier, scaling multiplier, serial divider and output register.
// Depends on bgh_pkg; driven by bgh_ctrl through cmd_t / sts_t.
module bgh_dp import bgh_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  cmd_t                      cmd,
	output sts_t                      sts,
	input  opcode_t                   opcode,
	input  logic [PIXEL_BITS-1:0]     pixel,
	input  logic [IDX_BITS-1:0]       bin_index,
	input  logic                      cfg_valid,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [STARS_BITS-1:0]     stars,
	output logic                      no_data
);

	localparam int W_RESET     = GREY_LEVELS / BIN_COUNT_RESET;
	localparam int RECIP_RESET = ((1 << RECIP_SHIFT) + W_RESET - 1) / W_RESET;
	localparam int PROD_BITS   = COUNT_BITS + STARS_BITS;

	// ceil(2^16 / bin_width) for each bin_count / 2
	logic [RECIP_BITS-1:0] recip_lut [STORE_DEPTH];

	for (genvar h = 0; h < STORE_DEPTH; h++) begin : g_recip
		localparam int W = GREY_LEVELS / (2 * h + ((h == 0) ? 1 : 0));
		localparam int M = (h == 0 || W == 0) ? 0 :
			((1 << RECIP_SHIFT) + W - 1) / (W + ((W == 0) ? 1 : 0));
		assign recip_lut[h] = RECIP_BITS'(M);
	end

	// configuration
	logic [STARS_BITS-1:0] scale_q;
	logic [BC_BITS-1:0]    bc_q;
	logic [RECIP_BITS-1:0] recip_q;
	logic [BC_BITS-1:0]    bc_wr;
	logic                  bc_ok;

	assign bc_wr = cfg_data[BC_BITS-1:0];
	assign bc_ok = (bc_wr != '0) && !bc_wr[0] && ({23'd0, bc_wr} <= 32'(GREY_LEVELS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= STARS_BITS'(STAR_SCALE_RESET);
			bc_q    <= BC_BITS'(BIN_COUNT_RESET);
			recip_q <= RECIP_BITS'(RECIP_RESET);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_STAR_SCALE: scale_q <= cfg_data[STARS_BITS-1:0];
				CFG_BIN_COUNT: begin
					if (bc_ok) begin
						bc_q    <= bc_wr;
						recip_q <= recip_lut[bc_wr[BC_BITS-1:1]];
					end
				end
				default: ;
			endcase
		end
	end

	// binning: pixel / width by reciprocal, exact for 8-bit pixels
	logic [PIXEL_BITS+RECIP_BITS-1:0] bin_prod;
	logic [IDX_BITS-1:0]              pix_bin;
	logic [IDX_BITS-1:0]              idx_sel;
	logic [IDX_BITS-1:0]              idx_q;
	logic                             in_range_q;

	assign bin_prod = {{RECIP_BITS{1'b0}}, pixel} * {{PIXEL_BITS{1'b0}}, recip_q};
	assign pix_bin  = bin_prod[RECIP_SHIFT +: IDX_BITS];
	assign idx_sel  = (opcode == OP_READ) ? bin_index : pix_bin;

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			idx_q      <= idx_sel;
			in_range_q <= ({1'b0, idx_sel} < bc_q);
		end
	end

	// bin store with per-entry valid bits
	logic [COUNT_BITS-1:0]  mem_q [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] valid_q;
	logic [COUNT_BITS-1:0]  rd_data_q;
	logic                   rd_valid_q;
	logic [COUNT_BITS-1:0]  cur_cnt;
	logic [COUNT_BITS-1:0]  new_cnt;
	logic [COUNT_BITS-1:0]  max_q;

	assign cur_cnt = rd_valid_q ? rd_data_q : '0;
	assign new_cnt = (&cur_cnt) ? cur_cnt : cur_cnt + COUNT_BITS'(1);

	always_ff @(posedge clk) begin
		if (cmd.mem_wr) begin
			mem_q[idx_q] <= new_cnt;
		end
		if (cmd.mem_rd) begin
			rd_data_q  <= mem_q[idx_q];
			rd_valid_q <= valid_q[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			max_q   <= '0;
		end else if (cmd.clear) begin
			valid_q <= '0;
			max_q   <= '0;
		end else if (cmd.mem_wr) begin
			valid_q[idx_q] <= 1'b1;
			if (new_cnt > max_q) begin
				max_q <= new_cnt;
			end
		end
	end

	// count * scale, then restoring division by the maximum; the quotient
	// never exceeds scale, so only the low 16 quotient bits are formed
	logic [PROD_BITS-1:0]  prod;
	logic [COUNT_BITS-1:0] rem_q;
	logic [STARS_BITS-1:0] quo_q;
	logic [STEP_BITS-1:0]  step_q;
	logic [COUNT_BITS:0]   trial;
	logic                  fits;

	assign prod  = {{STARS_BITS{1'b0}}, cur_cnt} * {{COUNT_BITS{1'b0}}, scale_q};
	assign trial = {rem_q, quo_q[STARS_BITS-1]};
	assign fits  = (trial >= {1'b0, max_q});

	always_ff @(posedge clk) begin
		if (cmd.mul_load) begin
			rem_q <= prod[PROD_BITS-1:STARS_BITS];
			quo_q <= prod[STARS_BITS-1:0];
		end else if (cmd.div_step) begin
			rem_q <= fits ? COUNT_BITS'(trial - {1'b0, max_q}) : trial[COUNT_BITS-1:0];
			quo_q <= {quo_q[STARS_BITS-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.mul_load) begin
			step_q <= '0;
		end else if (cmd.div_step) begin
			step_q <= step_q + STEP_BITS'(1);
		end
	end

	// output register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			stars   <= (in_range_q && (max_q != '0)) ? quo_q : '0;
			no_data <= (max_q == '0);
		end
	end

	assign m_tvalid     = out_valid_q;
	assign sts.in_range = in_range_q;
	assign sts.max_zero = (max_q == '0);
	assign sts.div_last = (step_q == STEP_BITS'(STARS_BITS - 1));
	assign sts.out_busy = out_valid_q && !m_tready;

endmodule

FILE: sv/bgh_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the binned grey histogram unit, bound to the top level.
// Depends on bgh_pkg for the opcode codes.
module bgh_checker import bgh_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tuser
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// an empty histogram answers zero stars
	a_no_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("no_data with non-zero stars");

	// a pixel update occupies the store for the next cycle
	a_add_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == OP_ADD) |=> !s_tready)
		else $error("input taken during pixel update");

	// a result is loaded only from the busy read sequence
	a_out_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared while idle");

endmodule

bind binned_grey_histogram_unit bgh_checker u_bgh_checker (.*);
